@@ rtl/sensor_alert_and_ring_log_assert.svh @@
// Assertion macros used by the checker module sal_checker.
`ifndef SENSOR_ALERT_AND_RING_LOG_ASSERT_SVH
`define SENSOR_ALERT_AND_RING_LOG_ASSERT_SVH

// Same-cycle implication.
`define SAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the next cycle.
`define SAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Delayed consequence.
`define SAL_ASSERT_AFTER2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

@@ rtl/sal_pkg.sv @@
package sal_pkg;

  localparam int SENSORS   = 8;
  localparam int LOG_DEPTH = 64;

  localparam int SAW   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int LAW   = $clog2(LOG_DEPTH);
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W = ((LAW > 6) ? LAW : 6) + 1;

  localparam logic [1:0] KIND_READING   = 2'd0;
  localparam logic [1:0] KIND_LOG_READ  = 2'd1;
  localparam logic [1:0] KIND_LOG_CLEAR = 2'd2;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_ABOVE  = 2'd1;
  localparam logic [1:0] MODE_BELOW  = 2'd2;
  localparam logic [1:0] MODE_CHANGE = 2'd3;

  localparam logic [1:0] REG_ALERT_MODE   = 2'd0;
  localparam logic [1:0] REG_TRIP_LEVEL   = 2'd1;
  localparam logic [1:0] REG_LOGGING_MASK = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         sensor_num;
    logic signed [31:0] sample;
    logic [31:0]        stamp;
    logic [5:0]         log_index;
  } sal_req_t;

  typedef struct packed {
    logic               alert;
    logic [31:0]        alert_total;
    logic [6:0]         fill;
    logic               entry_ok;
    logic [2:0]         entry_sensor;
    logic [31:0]        entry_time;
    logic signed [31:0] entry_value;
  } sal_rsp_t;

  typedef struct packed {
    logic signed [31:0] last_value;
    logic [31:0]        alert_total;
  } sal_sens_t;

  typedef struct packed {
    logic [2:0]         sensor;
    logic [31:0]        stamp;
    logic signed [31:0] value;
  } sal_entry_t;

endpackage

@@ rtl/sal_sensor_mem.sv @@
module sal_sensor_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [sal_pkg::SAW-1:0]    rd_addr,
  output sal_pkg::sal_sens_t         rd_data,
  input  logic                       wr_en,
  input  logic [sal_pkg::SAW-1:0]    wr_addr,
  input  sal_pkg::sal_sens_t         wr_data
);
  import sal_pkg::*;

  sal_sens_t          mem [SENSORS];
  logic [SENSORS-1:0] valid;
  sal_sens_t          rd_q;
  logic               rd_valid;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

@@ rtl/sal_log_ram.sv @@
module sal_log_ram (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [sal_pkg::LAW-1:0] rd_addr,
  output sal_pkg::sal_entry_t     rd_data,
  input  logic                    wr_en,
  input  logic [sal_pkg::LAW-1:0] wr_addr,
  input  sal_pkg::sal_entry_t     wr_data
);
  import sal_pkg::*;

  sal_entry_t mem [LOG_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sensor_alert_and_ring_log.sv @@
// Sensor alert checker with a ring log of readings.
// Request channel: start/busy. A request is taken at a clock edge with
//   start high and busy low; req carries kind, sensor, sample, stamp and
//   log index. Kinds: new reading, read log entry, clear log.
// Result channel: done pulses for one cycle with result valid; the receiver
//   cannot stall it and must take it in that cycle.
// Result path: the request is registered at the accepting edge, and done
//   and result are registered at the edge that ends ST_EXEC. No new request
//   is taken while one is in ST_EXEC, set by the read-modify-write of the
//   per-sensor table and the ring log RAM (read issued at the accepting edge,
//   write back at the next edge). busy is high in the cycle between them.
// Configuration: cfg_we/cfg_index/cfg_data write alert mode, threshold and
//   logging mask; write only while no request is in flight.
// Reset (rst, synchronous): state to idle; done, head, count and config
//   to zero; per-sensor last values and alert counts read as zero, log
//   empty; no clearing pass, requests are taken in the cycle after reset.
module sensor_alert_and_ring_log (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sal_pkg::sal_req_t req,
  output logic              done,
  output sal_pkg::sal_rsp_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import sal_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t             state;
  sal_req_t           cur;
  logic               cur_ok;
  logic [1:0]         alert_mode;
  logic signed [31:0] trip_level;
  logic [7:0]         logging_mask;
  logic [LAW-1:0]     head;
  logic [CNT_W-1:0]   count;

  logic               accept;
  logic               exec;
  logic [LAW-1:0]     start_pos;
  logic [SUM_W-1:0]   pos_sum;
  logic [LAW-1:0]     rd_pos;
  sal_sens_t          sens_rd;
  sal_sens_t          sens_wr;
  sal_entry_t         log_rd;
  sal_entry_t         log_wr;
  logic               in_range;
  logic               is_reading;
  logic               log_we;
  logic signed [33:0] diff;
  logic signed [33:0] mag;
  logic               hit;
  logic [31:0]        total_new;
  logic [LAW-1:0]     head_next;
  logic [CNT_W-1:0]   count_next;
  sal_rsp_t           result_next;

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;
  assign exec   = (state == ST_EXEC);

  // Oldest entry sits at 0 until the ring wraps, then at head.
  assign start_pos = (count < CNT_W'(LOG_DEPTH)) ? '0 : head;
  assign pos_sum   = SUM_W'(start_pos) + SUM_W'(req.log_index);
  assign rd_pos    = (pos_sum >= SUM_W'(LOG_DEPTH)) ? LAW'(pos_sum - SUM_W'(LOG_DEPTH))
                                                    : LAW'(pos_sum);

  sal_sensor_mem u_sens (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (SAW'(req.sensor_num)),
    .rd_data (sens_rd),
    .wr_en   (exec && is_reading),
    .wr_addr (SAW'(cur.sensor_num)),
    .wr_data (sens_wr)
  );

  sal_log_ram u_log (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_pos),
    .rd_data (log_rd),
    .wr_en   (log_we),
    .wr_addr (head),
    .wr_data (log_wr)
  );

  assign in_range   = (32'(cur.sensor_num) < SENSORS);
  assign is_reading = (cur.kind == KIND_READING) && in_range;
  assign log_we     = exec && is_reading && logging_mask[cur.sensor_num];

  assign diff = 34'(cur.sample) - 34'(sens_rd.last_value);
  assign mag  = diff[33] ? -diff : diff;

  always_comb begin
    unique case (alert_mode)
      MODE_NONE:   hit = 1'b0;
      MODE_ABOVE:  hit = cur.sample > trip_level;
      MODE_BELOW:  hit = cur.sample < trip_level;
      MODE_CHANGE: hit = mag > 34'(trip_level);
      default:     hit = 1'b0;
    endcase
  end

  assign total_new           = sens_rd.alert_total + 32'(hit);
  assign sens_wr.last_value  = cur.sample;
  assign sens_wr.alert_total = total_new;
  assign log_wr.sensor       = cur.sensor_num;
  assign log_wr.stamp        = cur.stamp;
  assign log_wr.value        = cur.sample;

  always_comb begin
    head_next  = head;
    count_next = count;
    if (cur.kind == KIND_LOG_CLEAR) begin
      head_next  = '0;
      count_next = '0;
    end else if (log_we) begin
      head_next = (head == LAW'(LOG_DEPTH - 1)) ? '0 : head + 1'b1;
      if (count < CNT_W'(LOG_DEPTH)) begin
        count_next = count + 1'b1;
      end
    end
  end

  always_comb begin
    result_next      = '0;
    result_next.fill = 7'(count_next);
    if (is_reading) begin
      result_next.alert       = hit;
      result_next.alert_total = total_new;
    end
    if (cur.kind == KIND_LOG_READ && cur_ok) begin
      result_next.entry_ok     = 1'b1;
      result_next.entry_sensor = log_rd.sensor;
      result_next.entry_time   = log_rd.stamp;
      result_next.entry_value  = log_rd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alert_mode   <= '0;
      trip_level   <= '0;
      logging_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALERT_MODE:   alert_mode   <= cfg_data[1:0];
        REG_TRIP_LEVEL:   trip_level   <= cfg_data;
        REG_LOGGING_MASK: logging_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      head  <= '0;
      count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          head  <= head_next;
          count <= count_next;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur    <= req;
      cur_ok <= (32'(req.log_index) < 32'(count));
    end
    if (exec) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/sal_checker.sv @@
module sal_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input sal_pkg::sal_rsp_t result
);
  import sal_pkg::*;

  `include "sensor_alert_and_ring_log_assert.svh"

  `SAL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `SAL_ASSERT_AFTER2(a_latency, start && !busy, done, "result missing two cycles after request")
  `SAL_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
  `SAL_ASSERT_NOW(a_entry_zero, done && !result.entry_ok,
    result.entry_sensor == 3'd0 && result.entry_time == 32'd0 && result.entry_value == 32'sd0,
    "entry fields set without a valid log entry")
  `SAL_ASSERT_NOW(a_fill_max, done, 32'(result.fill) <= LOG_DEPTH, "fill beyond log depth")

endmodule

bind sensor_alert_and_ring_log sal_checker u_sal_checker (.*);

@@ tb/alert_log_checker.sv @@
`timescale 1ns / 100ps

module alert_log_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  sal_pkg::sal_req_t req,
  input  logic              done,
  input  sal_pkg::sal_rsp_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                mismatches,
  output int                in_flight,
  output int                taken,
  output int                alerts_seen,
  output int                entries_read,
  output int                overwrites
);
  import sal_pkg::*;

  logic [1:0]         mode;
  logic signed [31:0] threshold;
  logic [7:0]         mask;
  logic signed [31:0] last_val [SENSORS];
  logic [31:0]        alert_cnt [SENSORS];
  sal_entry_t         ring [LOG_DEPTH];
  logic [LAW-1:0]     head;
  logic [CNT_W-1:0]   held;
  sal_rsp_t           expected_results [$];

  function automatic logic hits_rule(logic [2:0] s, logic signed [31:0] v);
    longint d;
    case (mode)
      MODE_ABOVE: return v > threshold;
      MODE_BELOW: return v < threshold;
      MODE_CHANGE: begin
        d = longint'(v) - longint'(last_val[s]);
        if (d < 0) d = -d;
        return d > longint'(threshold);
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic sal_rsp_t alert_log_step(sal_req_t r);
    sal_rsp_t       o;
    logic [LAW-1:0] pos;
    o = '0;
    case (r.kind)
      KIND_READING: begin
        if (r.sensor_num < SENSORS) begin
          if (hits_rule(r.sensor_num, r.sample)) begin
            o.alert = 1'b1;
            alert_cnt[r.sensor_num] = alert_cnt[r.sensor_num] + 1;
          end
          o.alert_total = alert_cnt[r.sensor_num];
          last_val[r.sensor_num] = r.sample;
          if (mask[r.sensor_num]) begin
            ring[head] = {r.sensor_num, r.stamp, r.sample};
            head = head + 1'b1;
            if (held < LOG_DEPTH) held = held + 1'b1;
            else overwrites++;
          end
        end
      end
      KIND_LOG_READ: begin
        if (r.log_index < held) begin
          // oldest entry sits at head once the ring has wrapped
          pos = ((held < LOG_DEPTH) ? '0 : head) + r.log_index;
          o.entry_ok = 1'b1;
          o.entry_sensor = ring[pos].sensor;
          o.entry_time = ring[pos].stamp;
          o.entry_value = ring[pos].value;
        end
      end
      KIND_LOG_CLEAR: begin
        head = '0;
        held = '0;
      end
      default: ;
    endcase
    o.fill = held;
    return o;
  endfunction

  task automatic note(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    sal_rsp_t e;
    if (rst) begin
      mode = MODE_NONE;
      threshold = '0;
      mask = '0;
      for (int i = 0; i < SENSORS; i++) begin
        last_val[i] = '0;
        alert_cnt[i] = '0;
      end
      for (int i = 0; i < LOG_DEPTH; i++) ring[i] = '0;
      head = '0;
      held = '0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          note($sformatf("result with no request waiting: %p", result));
        end else begin
          e = expected_results.pop_front();
          if (result.alert !== e.alert)
            note($sformatf("alert expected %0d got %0d", e.alert, result.alert));
          if (result.alert_total !== e.alert_total)
            note($sformatf("alert_total expected %0d got %0d", e.alert_total,
                           result.alert_total));
          if (result.fill !== e.fill)
            note($sformatf("fill expected %0d got %0d", e.fill, result.fill));
          if (result.entry_ok !== e.entry_ok)
            note($sformatf("entry_ok expected %0d got %0d", e.entry_ok, result.entry_ok));
          if (result.entry_sensor !== e.entry_sensor)
            note($sformatf("entry_sensor expected %0d got %0d", e.entry_sensor,
                           result.entry_sensor));
          if (result.entry_time !== e.entry_time)
            note($sformatf("entry_time expected %h got %h", e.entry_time,
                           result.entry_time));
          if (result.entry_value !== e.entry_value)
            note($sformatf("entry_value expected %h got %h", e.entry_value,
                           result.entry_value));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ALERT_MODE:   mode = cfg_data[1:0];
          REG_TRIP_LEVEL:   threshold = cfg_data;
          REG_LOGGING_MASK: mask = cfg_data[7:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        e = alert_log_step(req);
        taken++;
        if (e.alert) alerts_seen++;
        if (e.entry_ok) entries_read++;
        expected_results.push_back(e);
      end
    end
    in_flight = expected_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import sal_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  sal_req_t    req = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ALERT_MODE;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        done;
  sal_rsp_t    result;

  int mismatches, in_flight, taken, alerts_seen, entries_read, overwrites;
  int quiet = 0;
  int idle_pct = 0;
  logic [31:0] thr_now = '0;

  sensor_alert_and_ring_log dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  alert_log_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .done         (done),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .in_flight    (in_flight),
    .taken        (taken),
    .alerts_seen  (alerts_seen),
    .entries_read (entries_read),
    .overwrites   (overwrites)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic sal_req_t mk(logic [1:0] k, logic [2:0] s, logic [31:0] v,
                                  logic [31:0] t, logic [5:0] i);
    return {k, s, v, t, i};
  endfunction

  function automatic sal_req_t rand_req();
    sal_req_t r;
    int p;
    r.sensor_num = 3'($urandom_range(7));
    r.stamp = $urandom;
    r.log_index = ($urandom_range(7) == 0) ? 6'd63 : 6'($urandom_range(63));
    case ($urandom_range(3))
      0: r.sample = $urandom;
      1: r.sample = thr_now + ($urandom_range(4) - 2);
      2: case ($urandom_range(3))
           0: r.sample = 32'h7FFFFFFF;
           1: r.sample = 32'h80000000;
           2: r.sample = 32'h0;
           default: r.sample = 32'hFFFFFFFF;
         endcase
      default: r.sample = $urandom_range(200) - 100;
    endcase
    p = $urandom_range(999);
    if (p < 550) r.kind = KIND_READING;
    else if (p < 950) r.kind = KIND_LOG_READ;
    else if (p < 953) r.kind = KIND_LOG_CLEAR;
    else r.kind = KIND_UNUSED;
    return r;
  endfunction

  task automatic send_req(sal_req_t r);
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(logic [1:0] m, logic [31:0] t, logic [7:0] k);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_ALERT_MODE;
    cfg_data <= {30'd0, m};
    @(negedge clk);
    cfg_index <= REG_TRIP_LEVEL;
    cfg_data <= t;
    @(negedge clk);
    cfg_index <= REG_LOGGING_MASK;
    cfg_data <= {24'd0, k};
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_now = t;
  endtask

  initial begin
    logic [1:0]  m;
    logic [31:0] t;
    logic [7:0]  k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    configure(MODE_ABOVE, 32'h0, 8'hFF);
    send_req(mk(KIND_LOG_READ, 0, 0, 0, 0));
    send_req(mk(KIND_READING, 0, 32'h7FFFFFFF, 32'hFFFFFFFF, 0));
    send_req(mk(KIND_READING, 7, 32'h80000000, 32'h0, 6'd63));
    send_req(mk(KIND_READING, 3, 32'h0, 32'h5555AAAA, 0));
    send_req(mk(KIND_LOG_READ, 7, 32'hFFFFFFFF, 32'hFFFFFFFF, 0));
    send_req(mk(KIND_LOG_READ, 0, 0, 0, 2));
    send_req(mk(KIND_LOG_READ, 0, 0, 0, 3));
    send_req(mk(KIND_LOG_READ, 0, 0, 0, 6'd63));
    send_req(mk(KIND_UNUSED, 5, 32'hFFFFFFFF, 32'hFFFFFFFF, 1));
    send_req(mk(KIND_LOG_CLEAR, 0, 0, 0, 0));
    send_req(mk(KIND_LOG_READ, 0, 0, 0, 0));

    configure(MODE_CHANGE, 32'h7FFFFFFF, 8'h0F);
    send_req(mk(KIND_READING, 0, 32'h80000000, 32'h1, 0));
    send_req(mk(KIND_READING, 7, 32'h7FFFFFFF, 32'h2, 0));
    send_req(mk(KIND_READING, 1, 32'h5, 32'h3, 0));
    send_req(mk(KIND_LOG_READ, 0, 0, 0, 1));

    configure(MODE_BELOW, 32'h80000000, 8'h00);
    send_req(mk(KIND_READING, 2, 32'h80000000, 32'h4, 0));
    send_req(mk(KIND_READING, 2, 32'h80000001, 32'h5, 0));

    configure(MODE_NONE, 32'hFFFFFFFF, 8'hF0);
    send_req(mk(KIND_READING, 4, 32'h7FFFFFFF, 32'h6, 0));
    send_req(mk(KIND_LOG_READ, 0, 0, 0, 0));

    for (int ph = 0; ph < 16; ph++) begin
      m = 2'(ph % 4);
      case (ph)
        1:  t = 32'h80000000;
        2:  t = 32'h7FFFFFFF;
        3:  t = 32'h7FFFFFFF;
        5:  t = 32'h0;
        7:  t = 32'h80000000;
        default: t = (m == MODE_CHANGE) ? 32'($urandom_range(300)) : $urandom;
      endcase
      if (ph % 3 == 0) k = 8'hFF;
      else if (ph == 4) k = 8'h00;
      else k = 8'($urandom_range(255));
      configure(m, t, k);
      // the receiver cannot stall; idle gaps between requests vary with the phase group
      case ((ph / 4) % 4)
        1: idle_pct = 65;
        3: idle_pct = 23;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 100; n++) begin
        send_req(rand_req());
        maybe_gap();
      end
    end

    drain();
    $display("%0d requests: %0d alerts, %0d log entries read back, %0d ring overwrites",
             taken, alerts_seen, entries_read, overwrites);
    $display("all four alert modes, threshold and sample extremes, log clear and wrap");
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
